// ===== design/pit_pkg.sv =====
package pit_pkg;

   // Request codes carried in the operation field
   typedef enum logic [1:0] {
      OP_WRITE_PALETTE = 2'd0,
      OP_WRITE_ICON    = 2'd1,
      OP_READ_SMALL    = 2'd2,
      OP_READ_LARGE    = 2'd3
   } op_type;

   localparam int INDEX_W       = 12;
   localparam int VALUE_W       = 16;
   localparam int COLOR_W       = 16;

   localparam int PALETTE_DEPTH = 16;
   localparam int PALETTE_W     = 15;
   localparam int ICON_DEPTH    = 'h200;
   localparam int ICON_W        = 8;

   localparam int SMALL_SIDE    = 24;
   localparam int LARGE_SIDE    = 48;
   localparam int LARGE_OFFSET  = 8;

   localparam logic [COLOR_W-1:0] WHITE_565 = 16'hFFFF;

   typedef struct packed {
      op_type               operation;
      logic [INDEX_W-1:0]   index;
      logic [VALUE_W-1:0]   value;
   } req_item_type;

   typedef struct packed {
      logic [COLOR_W-1:0]   pixel_color;
      logic                 bad_index;
   } rsp_item_type;

endpackage

// ===== design/pit_if.sv =====
interface pit_req_if;
   logic                  valid;
   logic                  ready;
   pit_pkg::req_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

interface pit_rsp_if;
   logic                  valid;
   logic                  ready;
   pit_pkg::rsp_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

// ===== design/pit_ram.sv =====
module pit_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]          wr_data,
   input  logic                      rd_en,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the old contents when the same entry is written in that cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/palette_icon_to_tiled_icon.sv =====
// Channel   Dir  Payload                               Handshake
// req_port  in   operation[1:0] index[11:0] value[15:0] valid/ready
// rsp_port  out  pixel_color[15:0] bad_index           valid/ready
//
// A write item produces no item on rsp_port.
// A read item passes icon memory read, palette memory read and the output
// register in that order, and the next item is taken only once no read is
// in flight, at the earliest in the cycle in which its result leaves.
// Reset (synchronous) empties the pipeline and output register; memory
// contents are left as they are. A stalled rsp_port holds the result and
// blocks new items until it is taken.
module palette_icon_to_tiled_icon (
   input  logic       clock,
   input  logic       reset,
   pit_req_if.sink    req_port,
   pit_rsp_if.source  rsp_port
);
   import pit_pkg::*;

   localparam int PAL_AW  = $clog2(PALETTE_DEPTH);
   localparam int ICON_AW = $clog2(ICON_DEPTH);

   // Widen BGR555 to RGB565, repeating the top green bit
   function automatic logic [COLOR_W-1:0] widen_color(input logic [PALETTE_W-1:0] c);
      widen_color = {c[4:0], c[9:5], c[9], c[14:10]};
   endfunction

   // ---------------------------------------------------------------------
   // Accept stage: decode, untile, map to source byte address
   // ---------------------------------------------------------------------
   logic               req_fire;
   logic               is_read;
   logic [2:0]         px;
   logic [2:0]         py;

   logic [3:0]         tile_s;
   logic [7:0]         tile_s_prod;
   logic [1:0]         ty_s;
   logic [1:0]         tx_s;
   logic [4:0]         x_s;
   logic [4:0]         y_s;
   logic [12:0]        sx_s_prod;
   logic [12:0]        sy_s_prod;
   logic [4:0]         sx_s;
   logic [4:0]         sy_s;

   logic [5:0]         tile_l;
   logic [11:0]        tile_l_prod;
   logic [2:0]         ty_l;
   logic [2:0]         tx_l;
   logic [5:0]         x_l;
   logic [5:0]         y_l;
   logic               inside_l;
   logic [4:0]         sx_l;
   logic [4:0]         sy_l;

   logic [4:0]         sx;
   logic [4:0]         sy;
   logic               bad_in;
   logic               white_in;

   logic               pal_wr_en;
   logic               icon_wr_en;
   logic [ICON_AW-1:0] icon_rd_addr;

   assign px = {req_port.item.index[4], req_port.item.index[2], req_port.item.index[0]};
   assign py = {req_port.item.index[5], req_port.item.index[3], req_port.item.index[1]};

   // Small icon: three tiles across, tile / 3 by reciprocal multiply
   assign tile_s      = req_port.item.index[9:6];
   assign tile_s_prod = 8'(tile_s) * 8'd11;
   assign ty_s        = tile_s_prod[6:5];
   assign tx_s        = 2'(tile_s - 4'(ty_s) * 4'd3);
   assign x_s         = {tx_s, px};
   assign y_s         = {ty_s, py};
   // Source coordinate c*32/24 = floor(4c/3) = (c*171) >> 7 for c < 24
   assign sx_s_prod   = 13'(x_s) * 13'd171;
   assign sy_s_prod   = 13'(y_s) * 13'd171;
   assign sx_s        = sx_s_prod[11:7];
   assign sy_s        = sy_s_prod[11:7];

   // Large icon: six tiles across, tile / 6 by reciprocal multiply
   assign tile_l      = req_port.item.index[11:6];
   assign tile_l_prod = 12'(tile_l) * 12'd43;
   assign ty_l        = tile_l_prod[10:8];
   assign tx_l        = 3'(tile_l - 6'(ty_l) * 6'd6);
   assign x_l         = {tx_l, px};
   assign y_l         = {ty_l, py};
   assign inside_l    = (x_l >= 6'(LARGE_OFFSET)) && (x_l < 6'(LARGE_OFFSET + 32))
                     && (y_l >= 6'(LARGE_OFFSET)) && (y_l < 6'(LARGE_OFFSET + 32));
   assign sx_l        = 5'(x_l - 6'(LARGE_OFFSET));
   assign sy_l        = 5'(y_l - 6'(LARGE_OFFSET));

   always_comb begin
      is_read  = 1'b0;
      bad_in   = 1'b0;
      white_in = 1'b0;
      sx       = sx_s;
      sy       = sy_s;
      unique case (req_port.item.operation)
         OP_WRITE_PALETTE, OP_WRITE_ICON: begin
            is_read = 1'b0;
         end
         OP_READ_SMALL: begin
            is_read = 1'b1;
            bad_in  = (req_port.item.index >= INDEX_W'(SMALL_SIDE * SMALL_SIDE));
         end
         OP_READ_LARGE: begin
            is_read  = 1'b1;
            bad_in   = (req_port.item.index >= INDEX_W'(LARGE_SIDE * LARGE_SIDE));
            white_in = !inside_l;
            sx       = sx_l;
            sy       = sy_l;
         end
         default: begin
            is_read = 1'b0;
         end
      endcase
   end

   // Byte address: tile row, tile column, row in tile, pixel pair
   assign icon_rd_addr = {sy[4:3], sx[4:3], sy[2:0], sx[2:1]};

   assign req_fire   = req_port.valid && req_port.ready;
   assign pal_wr_en  = req_fire && (req_port.item.operation == OP_WRITE_PALETTE)
                    && (req_port.item.index < INDEX_W'(PALETTE_DEPTH));
   assign icon_wr_en = req_fire && (req_port.item.operation == OP_WRITE_ICON)
                    && (req_port.item.index < INDEX_W'(ICON_DEPTH));

   // ---------------------------------------------------------------------
   // Pipeline control
   // ---------------------------------------------------------------------
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_bad_ff;
   logic               s1_white_ff;
   logic               s1_high_ff;
   logic               s2_valid_ff, s2_valid_in;
   logic               s2_bad_ff;
   logic               s2_white_ff;
   logic               out_valid_ff, out_valid_in;
   rsp_item_type       out_item_ff, out_item_in;

   logic [ICON_W-1:0]    icon_rd_data;
   logic [PAL_AW-1:0]    pal_rd_addr;
   logic [PALETTE_W-1:0] pal_rd_data;

   // Take a new item only with no read in flight and the output free or being taken
   assign req_port.ready = !s1_valid_ff && !s2_valid_ff
                        && (!out_valid_ff || rsp_port.ready);

   assign s1_valid_in = req_fire && is_read;
   assign s2_valid_in = s1_valid_ff;

   // Pick the nibble; even x sits in the low half of the byte
   assign pal_rd_addr = s1_high_ff ? icon_rd_data[7:4] : icon_rd_data[3:0];

   always_comb begin
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (rsp_port.valid && rsp_port.ready) begin
         out_valid_in = 1'b0;
      end
      if (s2_valid_ff) begin
         out_valid_in = 1'b1;
         if (s2_bad_ff) begin
            out_item_in.pixel_color = '0;
            out_item_in.bad_index   = 1'b1;
         end else if (s2_white_ff) begin
            out_item_in.pixel_color = WHITE_565;
            out_item_in.bad_index   = 1'b0;
         end else begin
            out_item_in.pixel_color = widen_color(pal_rd_data);
            out_item_in.bad_index   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload: no reset
   always_ff @(posedge clock) begin
      s1_bad_ff   <= bad_in;
      s1_white_ff <= white_in;
      s1_high_ff  <= sx[0];
      s2_bad_ff   <= s1_bad_ff;
      // Palette index zero reads as white, like the border
      s2_white_ff <= s1_white_ff || (pal_rd_addr == '0);
      out_item_ff <= out_item_in;
   end

   assign rsp_port.valid = out_valid_ff;
   assign rsp_port.item  = out_item_ff;

   // ---------------------------------------------------------------------
   // Memories
   // ---------------------------------------------------------------------
   pit_ram #(
      .WIDTH (ICON_W),
      .DEPTH (ICON_DEPTH)
   ) u_icon_ram (
      .clock   (clock),
      .wr_en   (icon_wr_en),
      .wr_addr (req_port.item.index[ICON_AW-1:0]),
      .wr_data (req_port.item.value[ICON_W-1:0]),
      .rd_en   (s1_valid_in),
      .rd_addr (icon_rd_addr),
      .rd_data (icon_rd_data)
   );

   // A later palette write in the lookup cycle must not be seen: the RAM reads old data
   pit_ram #(
      .WIDTH (PALETTE_W),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette_ram (
      .clock   (clock),
      .wr_en   (pal_wr_en),
      .wr_addr (req_port.item.index[PAL_AW-1:0]),
      .wr_data (req_port.item.value[PALETTE_W-1:0]),
      .rd_en   (s1_valid_ff),
      .rd_addr (pal_rd_addr),
      .rd_data (pal_rd_data)
   );

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_one_read_in_flight: assert property (@(posedge clock) disable iff (reset)
      $onehot0({s1_valid_ff, s2_valid_ff, out_valid_ff && !rsp_port.ready}))
      else $error("more than one read item in flight");

   a_read_enters_pipe: assert property (@(posedge clock) disable iff (reset)
      req_fire && is_read |=> s1_valid_ff)
      else $error("accepted read item did not enter the pipeline");

   a_result_from_pipe: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(s2_valid_ff))
      else $error("result appeared without a read in the last stage");

   a_bad_is_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_item_ff.bad_index |-> out_item_ff.pixel_color == '0)
      else $error("flagged result carries a nonzero color");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_port.ready |=> out_valid_ff && $stable(out_item_ff))
      else $error("stalled result changed");

endmodule
